>>> hdl/cbq_pkg.sv
`timescale 1ns / 1ps
// cbq_pkg: types and constants of the cascaded biquad filter.
// No dependencies; imported by cascaded_biquad_filter.
package cbq_pkg;

  localparam int COEFS_PER_SECTION = 5;
  localparam int FRAC_SHIFT        = 28;
  localparam int SAMPLE_W          = 24;
  localparam int STAGE_W           = 32;
  localparam int PROD_W            = 2 * STAGE_W;
  localparam int ACC_W             = PROD_W + 3;
  localparam int RND_W             = ACC_W - FRAC_SHIFT;
  localparam int HIST_W            = 4 * STAGE_W;
  localparam int CFG_W             = 4;
  localparam int STEP_W            = 3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_FILTER = 2'd0;
  localparam kind_t KIND_COEF   = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;

  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_ISSUE   = 3'd0;
  localparam step_t STEP_A0      = 3'd1;
  localparam step_t STEP_A1      = 3'd2;
  localparam step_t STEP_A2      = 3'd3;
  localparam step_t STEP_B1      = 3'd4;
  localparam step_t STEP_B2      = 3'd5;
  localparam step_t STEP_ACC_END = 3'd6;
  localparam step_t STEP_WB      = 3'd7;

  localparam logic [CFG_W-1:0] SECTIONS_RESET = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

endpackage

>>> hdl/cbq_ram.sv
`timescale 1ns / 1ps
// cbq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cascaded_biquad_filter.sv
`timescale 1ns / 1ps
// cascaded_biquad_filter: top level, cascade of direct-form-I biquads on one shared MAC.
// Depends on cbq_pkg and cbq_ram (coefficient and history memories).
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | kind, sample_in, section, coef_index, coef_value
//  out      | out_valid / out_stall| sample_out, saturated
//  cfg      | cfg_write            | cfg_data (sections in use)
//
// A filter transfer steps through issue, five products, accumulate end and write-back for
// each section in use, then the output state and back to idle; with no sections in use it
// goes straight to output. The single 32x32 multiplier, used five times per section, sets this pace.
// Coefficient writes and history clears complete on acceptance, without leaving idle.
// Reset is synchronous; valid bits make all stores read as zero, no clearing pass.
// A finished sample waits in the output register while out_stall is high.
module cascaded_biquad_filter
  import cbq_pkg::*;
#(
  parameter int MAX_SECTIONS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic signed [SAMPLE_W-1:0]  sample_in,
  input  logic [3:0]                  section,
  input  logic [2:0]                  coef_index,
  input  logic signed [STAGE_W-1:0]   coef_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  sample_out,
  output logic                        saturated
);

  localparam int COEF_DEPTH = COEFS_PER_SECTION * MAX_SECTIONS;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int SEC_W      = MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1;

  state_t                    state;
  logic [CFG_W-1:0]          sections_cfg;
  logic [CFG_W:0]            n_sec;
  logic [CFG_W:0]            n_eff;
  logic [SEC_W-1:0]          sec;
  logic [COEF_AW-1:0]        coef_base;
  step_t                     step;
  logic signed [STAGE_W-1:0] xin, hx1, hx2, hy1, hy2;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_neg;
  logic signed [ACC_W-1:0]   acc;
  logic                      sat_flag;
  logic [COEF_DEPTH-1:0]     coef_valid;
  logic [MAX_SECTIONS-1:0]   hist_valid;
  logic                      coef_ok, hist_ok;

  logic                      in_accept, out_load;
  logic [6:0]                coef_wfull;
  logic [COEF_AW-1:0]        coef_waddr, coef_raddr;
  logic                      coef_we;
  logic [STAGE_W-1:0]        coef_q;
  logic [HIST_W-1:0]         hist_q, hist_wdata;
  logic                      hist_we;
  logic signed [STAGE_W-1:0] coef_val, op, y_stage;
  logic signed [STAGE_W-1:0] h_x2, h_x1, h_y2, h_y1;
  logic signed [ACC_W-1:0]   term, rsum;
  logic signed [RND_W-1:0]   rshift;
  logic                      stage_clip, out_clip, last_sec;
  logic signed [SAMPLE_W-1:0] out_val;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign n_sec     = {1'b0, cfg_data};
  assign n_eff     = ({1'b0, sections_cfg} > (CFG_W + 1)'(MAX_SECTIONS)) ?
                     (CFG_W + 1)'(MAX_SECTIONS) : {1'b0, sections_cfg};

  // coefficient writes
  assign coef_wfull = 7'(section) * 7'd5 + 7'(coef_index);
  assign coef_waddr = coef_wfull[COEF_AW-1:0];
  assign coef_we    = in_accept && (kind == KIND_COEF) &&
                      ({1'b0, section} < 5'(MAX_SECTIONS)) &&
                      (coef_index < 3'(COEFS_PER_SECTION));
  assign coef_raddr = coef_base + COEF_AW'(step);

  cbq_ram #(.WIDTH(STAGE_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  // history word: x2, x1, y2, y1 from the top
  assign h_x2 = hist_ok ? hist_q[4*STAGE_W-1:3*STAGE_W] : '0;
  assign h_x1 = hist_ok ? hist_q[3*STAGE_W-1:2*STAGE_W] : '0;
  assign h_y2 = hist_ok ? hist_q[2*STAGE_W-1:STAGE_W]   : '0;
  assign h_y1 = hist_ok ? hist_q[STAGE_W-1:0]           : '0;

  assign hist_we    = (state == ST_RUN) && (step == STEP_WB);
  assign hist_wdata = {hx1, xin, hy1, y_stage};

  cbq_ram #(.WIDTH(HIST_W), .DEPTH(MAX_SECTIONS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (sec),
    .wdata (hist_wdata),
    .raddr (sec),
    .rdata (hist_q)
  );

  assign coef_val = coef_ok ? coef_q : '0;

  always_comb begin
    case (step)
      STEP_A0: op = xin;
      STEP_A1: op = hx1;
      STEP_A2: op = hx2;
      STEP_B1: op = hy1;
      STEP_B2: op = hy2;
      default: op = '0;
    endcase
  end

  assign term = prod_neg ? -ACC_W'(prod) : ACC_W'(prod);

  // round half up, floor shift, saturate to the stage width
  assign rsum       = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
  assign rshift     = rsum[ACC_W-1:FRAC_SHIFT];
  assign stage_clip = !((&rshift[RND_W-1:STAGE_W-1]) || !(|rshift[RND_W-1:STAGE_W-1]));
  assign y_stage    = stage_clip ? (rshift[RND_W-1] ? {1'b1, {(STAGE_W-1){1'b0}}}
                                                    : {1'b0, {(STAGE_W-1){1'b1}}})
                                 : rshift[STAGE_W-1:0];
  assign last_sec   = ((CFG_W + 1)'(sec) + (CFG_W + 1)'(1)) == n_eff;

  assign out_clip = !((&xin[STAGE_W-1:SAMPLE_W-1]) || !(|xin[STAGE_W-1:SAMPLE_W-1]));
  assign out_val  = out_clip ? (xin[STAGE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                               : {1'b0, {(SAMPLE_W-1){1'b1}}})
                             : xin[SAMPLE_W-1:0];
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sections_cfg <= SECTIONS_RESET;
      coef_valid   <= '0;
      hist_valid   <= '0;
      out_valid    <= 1'b0;
      step         <= STEP_ISSUE;
      sec          <= '0;
      coef_base    <= '0;
    end else begin
      if (cfg_write) begin
        sections_cfg <= n_sec[CFG_W-1:0];
      end
      if (coef_we) begin
        coef_valid[coef_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && (kind == KIND_CLEAR)) begin
            hist_valid <= '0;
          end
          if (in_accept && (kind == KIND_FILTER)) begin
            step      <= STEP_ISSUE;
            sec       <= '0;
            coef_base <= '0;
            state     <= (n_eff == '0) ? ST_OUT : ST_RUN;
          end
        end
        ST_RUN: begin
          if (step == STEP_WB) begin
            hist_valid[sec] <= 1'b1;
            step            <= STEP_ISSUE;
            if (last_sec) begin
              state <= ST_OUT;
            end else begin
              sec       <= sec + SEC_W'(1);
              coef_base <= coef_base + COEF_AW'(COEFS_PER_SECTION);
            end
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    coef_ok  <= coef_valid[coef_raddr];
    prod     <= PROD_W'(coef_val) * PROD_W'(op);
    prod_neg <= (step >= STEP_B1);
    if (step == STEP_ISSUE) begin
      hist_ok <= hist_valid[sec];
    end
    if (in_accept && (kind == KIND_FILTER)) begin
      xin      <= STAGE_W'(sample_in);
      sat_flag <= 1'b0;
    end
    if (state == ST_RUN) begin
      if (step == STEP_A0) begin
        hx1 <= h_x1;
        hx2 <= h_x2;
        hy1 <= h_y1;
        hy2 <= h_y2;
      end
      if (step == STEP_A1) begin
        acc <= term;
      end else if (step > STEP_A1 && step <= STEP_ACC_END) begin
        acc <= acc + term;
      end
      if (step == STEP_WB) begin
        xin      <= y_stage;
        sat_flag <= sat_flag | stage_clip;
      end
    end
    if (out_load) begin
      sample_out <= out_val;
      saturated  <= sat_flag | out_clip;
    end
  end

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (in_accept && kind == KIND_FILTER && n_eff == '0) |=> (state == ST_OUT))
    else $error("zero sections did not go straight to output");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && kind == KIND_FILTER && n_eff != '0) |=>
      (state == ST_RUN && step == STEP_ISSUE && sec == '0))
    else $error("filter transfer did not start at section zero");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((CFG_W + 1)'(sec) < n_eff))
    else $error("section index beyond sections in use");

  a_coef_base: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (7'(coef_base) == 7'(sec) * 7'd5))
    else $error("coefficient base out of step with section");

  a_hist_marked: assert property (@(posedge clk) disable iff (rst)
    hist_we |=> hist_valid[$past(sec)])
    else $error("written history entry not marked valid");

endmodule

>>> verif/cascaded_biquad_filter_test.sv
`timescale 1ns / 1ps
// cascaded_biquad_filter_test: self-checking bench for the biquad cascade, a directed table
// then phased random traffic with idling on both channels, checked against a local model.
// Depends on cbq_pkg and the cascaded_biquad_filter RTL.
module cascaded_biquad_filter_test;
  import cbq_pkg::*;

  localparam int MAX_SECTIONS  = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int FLUSH_CYCLES  = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int TOTAL_ITEMS   = 1350;
  localparam int TAIL_ITEMS    = 120;
  localparam int N_DIRECTED    = 26;

  localparam kind_t KIND_UNUSED = 2'd3;

  localparam logic [2:0] COEF_A0     = 3'd0;
  localparam logic [2:0] COEF_A1     = 3'd1;
  localparam logic [2:0] COEF_A2     = 3'd2;
  localparam logic [2:0] COEF_B1     = 3'd3;
  localparam logic [2:0] COEF_B2     = 3'd4;
  localparam logic [2:0] COEF_BAD_LO = 3'd5;
  localparam logic [2:0] COEF_BAD_HI = 3'd7;

  localparam longint STAGE_HI  = 64'sd2147483647;
  localparam longint STAGE_LO  = -64'sd2147483648;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 1 <<< (FRAC_SHIFT - 1);

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       sat;
  } filter_result_t;

  typedef struct {
    bit                         is_cfg;
    logic [CFG_W-1:0]           cfg_val;
    kind_t                      k;
    logic signed [SAMPLE_W-1:0] smp;
    logic [3:0]                 sec;
    logic [2:0]                 ci;
    logic signed [STAGE_W-1:0]  cv;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] want_smp;
    bit                         want_sat;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  kind_t                      kind;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [3:0]                 section;
  logic [2:0]                 coef_index;
  logic signed [STAGE_W-1:0]  coef_value;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       saturated;

  // model state
  bit signed [STAGE_W-1:0] coef_mem [0:COEFS_PER_SECTION*MAX_SECTIONS-1];
  bit signed [STAGE_W-1:0] x_hist [0:2*MAX_SECTIONS-1];
  bit signed [STAGE_W-1:0] y_hist [0:2*MAX_SECTIONS-1];
  bit [CFG_W-1:0]          active_sections = SECTIONS_RESET;

  filter_result_t pending_outputs [$];
  int  mismatches;
  int  item_count;
  int  calm_left;
  int  hold_asked, hold_given, hold_left, stall_left;
  bit  quiet, steady;

  stim_row_t directed [0:N_DIRECTED-1] = '{
    '{0, 4'd0,  KIND_FILTER, 24'h7FFFFF, 4'd0,  COEF_A0,     32'h00000000, 1, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h800000, 4'd0,  COEF_A0,     32'h00000000, 1, 24'h000000, 0},
    '{1, 4'd0,  KIND_FILTER, 24'h000000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h7FFFFF, 4'd0,  COEF_A0,     32'h00000000, 1, 24'h7FFFFF, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h800000, 4'd0,  COEF_A0,     32'h00000000, 1, 24'h800000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h000001, 4'd0,  COEF_A0,     32'h00000000, 1, 24'h000001, 0},
    '{0, 4'd0,  KIND_COEF,   24'h000000, 4'd0,  COEF_A0,     32'h10000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_COEF,   24'h000000, 4'd0,  COEF_BAD_LO, 32'h7FFFFFFF, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_COEF,   24'h000000, 4'd10, COEF_A0,     32'h7FFFFFFF, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_COEF,   24'hFFFFFF, 4'd15, COEF_BAD_HI, 32'hFFFFFFFF, 0, 24'h000000, 0},
    '{1, 4'd1,  KIND_FILTER, 24'h000000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h123456, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_COEF,   24'h000000, 4'd0,  COEF_A0,     32'h7FFFFFFF, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h7FFFFF, 4'd0,  COEF_A0,     32'h00000000, 1, 24'h7FFFFF, 1},
    '{0, 4'd0,  KIND_COEF,   24'h000000, 4'd0,  COEF_A0,     32'h80000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h7FFFFF, 4'd0,  COEF_A0,     32'h00000000, 1, 24'h800000, 1},
    '{0, 4'd0,  KIND_COEF,   24'h000000, 4'd0,  COEF_B1,     32'h80000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_COEF,   24'h000000, 4'd1,  COEF_A0,     32'h10000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_UNUSED, 24'h7FFFFF, 4'd15, COEF_BAD_HI, 32'hFFFFFFFF, 0, 24'h000000, 0},
    '{1, 4'd15, KIND_FILTER, 24'h000000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h400000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h800000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_CLEAR,  24'h000000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h7FFFFF, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{1, 4'd10, KIND_FILTER, 24'h000000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0},
    '{0, 4'd0,  KIND_FILTER, 24'h000000, 4'd0,  COEF_A0,     32'h00000000, 0, 24'h000000, 0}
  };

  cascaded_biquad_filter #(.MAX_SECTIONS(MAX_SECTIONS)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .sample_in  (sample_in),
    .section    (section),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

  always #4 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // one sample through the active sections, updating the histories
  function automatic filter_result_t run_cascade(input logic signed [SAMPLE_W-1:0] smp);
    logic signed [STAGE_W-1:0] v;
    logic signed [STAGE_W-1:0] y;
    logic signed [ACC_W-1:0]   acc;
    filter_result_t            r;
    int                        n;
    int                        s;
    int                        b;
    r.sat = 1'b0;
    v = STAGE_W'(smp);
    n = (active_sections > MAX_SECTIONS) ? MAX_SECTIONS : active_sections;
    for (s = 0; s < n; s++) begin
      b = s * COEFS_PER_SECTION;
      acc = ACC_W'(coef_mem[b]) * ACC_W'(v)
          + ACC_W'(coef_mem[b+1]) * ACC_W'(x_hist[2*s+1])
          + ACC_W'(coef_mem[b+2]) * ACC_W'(x_hist[2*s])
          - ACC_W'(coef_mem[b+3]) * ACC_W'(y_hist[2*s+1])
          - ACC_W'(coef_mem[b+4]) * ACC_W'(y_hist[2*s]);
      acc = (acc + ROUND_HALF) >>> FRAC_SHIFT;
      if (acc > STAGE_HI) begin
        y = STAGE_HI[STAGE_W-1:0];
        r.sat = 1'b1;
      end else if (acc < STAGE_LO) begin
        y = STAGE_LO[STAGE_W-1:0];
        r.sat = 1'b1;
      end else begin
        y = acc[STAGE_W-1:0];
      end
      x_hist[2*s]   = x_hist[2*s+1];
      x_hist[2*s+1] = v;
      y_hist[2*s]   = y_hist[2*s+1];
      y_hist[2*s+1] = y;
      v = y;
    end
    if (v > SAMPLE_HI) begin
      r.smp = SAMPLE_HI[SAMPLE_W-1:0];
      r.sat = 1'b1;
    end else if (v < SAMPLE_LO) begin
      r.smp = SAMPLE_LO[SAMPLE_W-1:0];
      r.sat = 1'b1;
    end else begin
      r.smp = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // mostly scaled-down values so that not every output clips
  function automatic logic signed [STAGE_W-1:0] rand_coef(input int min_shift);
    logic signed [STAGE_W-1:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 7) == 0) return raw;
    return raw >>> $urandom_range(min_shift, min_shift + 7);
  endfunction

  task automatic send_item(input kind_t k, input logic signed [SAMPLE_W-1:0] smp,
                           input logic [3:0] sec, input logic [2:0] ci,
                           input logic signed [STAGE_W-1:0] cv, input bit typed,
                           input logic signed [SAMPLE_W-1:0] want_smp, input bit want_sat);
    filter_result_t r;
    bit             addr_ok;
    addr_ok = (sec < MAX_SECTIONS) && (ci <= COEF_B2);
    if (!steady && !quiet) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        calm_left = $urandom_range(10, 40);
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        calm_left = $urandom_range(0, 4);
      end
    end
    in_valid   <= 1'b1;
    kind       <= k;
    sample_in  <= smp;
    section    <= sec;
    coef_index <= ci;
    coef_value <= cv;
    do @(posedge clk); while (in_stall);
    case (k)
      KIND_FILTER: begin
        r = run_cascade(smp);
        if (typed) begin
          r.smp = want_smp;
          r.sat = want_sat;
        end
        pending_outputs.push_back(r);
      end
      KIND_COEF: begin
        if (addr_ok) coef_mem[sec * COEFS_PER_SECTION + ci] = cv;
      end
      KIND_CLEAR: begin
        foreach (x_hist[i]) begin
          x_hist[i] = '0;
          y_hist[i] = '0;
        end
      end
      default: ;
    endcase
    item_count++;
    quiet = (item_count >= TOTAL_ITEMS - TAIL_ITEMS);
  endtask

  // register write only once the block has drained
  task automatic set_sections(input logic [CFG_W-1:0] n);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
    active_sections = n;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_given != hold_asked) begin
      hold_given = hold_given + 1;
      hold_left  = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 18);
        end
        1: begin
          out_stall <= 1'b0;
          stall_left = $urandom_range(20, 150);
        end
        default: begin
          out_stall <= 1'b0;
          stall_left = $urandom_range(0, 18);
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_outputs
    filter_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transfer, sample %0d flag %0b", $realtime, sample_out,
                   saturated);
      end else begin
        want = pending_outputs.pop_front();
        if (sample_out !== want.smp || saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: sample %0d flag %0b, expected sample %0d flag %0b", $realtime,
                     sample_out, saturated, want.smp, want.sat);
        end
      end
    end
  end

  initial begin : stimulus
    int                         phase;
    int                         len;
    int                         n_eff;
    int                         s;
    int                         c;
    int                         pick;
    logic [CFG_W-1:0]           cfg;
    kind_t                      k;
    logic signed [SAMPLE_W-1:0] smp;
    logic [3:0]                 sec;
    logic [2:0]                 ci;
    logic signed [STAGE_W-1:0]  cv;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= SECTIONS_RESET;
    in_valid   <= 1'b0;
    kind       <= KIND_FILTER;
    sample_in  <= '0;
    section    <= '0;
    coef_index <= COEF_A0;
    coef_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg)
        set_sections(directed[i].cfg_val);
      else
        send_item(directed[i].k, directed[i].smp, directed[i].sec, directed[i].ci,
                  directed[i].cv, directed[i].typed, directed[i].want_smp,
                  directed[i].want_sat);
    end

    phase = 0;
    while (item_count < TOTAL_ITEMS) begin
      phase++;
      case (phase)
        1: cfg = 4'd0;
        2: cfg = 4'd15;
        3: cfg = 4'd1;
        4: cfg = 4'd10;
        default: cfg = CFG_W'(($urandom_range(0, 2) != 0) ? $urandom_range(1, 4)
                                                           : $urandom_range(0, 15));
      endcase
      set_sections(cfg);
      n_eff = (cfg > MAX_SECTIONS) ? MAX_SECTIONS : cfg;

      // in early phases and at random after: fresh coefficients for the sections in use, maybe a clear
      if ($urandom_range(0, 1) == 0 || phase <= 4) begin
        for (s = 0; s < n_eff; s++)
          for (c = COEF_A0; c <= COEF_B2; c++)
            send_item(KIND_COEF, SAMPLE_W'($urandom), 4'(s), 3'(c),
                      rand_coef(c >= COEF_B1 ? 5 : 2), 1'b0, '0, 1'b0);
        if ($urandom_range(0, 1) == 0)
          send_item(KIND_CLEAR, SAMPLE_W'($urandom), 4'($urandom), 3'($urandom), $urandom,
                    1'b0, '0, 1'b0);
      end

      // back-pressure: receiver holds off while items keep coming
      if (phase == 5) begin
        hold_asked++;
        steady = 1'b1;
      end

      len = $urandom_range(20, 60);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        smp  = SAMPLE_W'($urandom);
        sec  = 4'($urandom);
        ci   = 3'($urandom);
        cv   = $urandom;
        if (pick < 72) begin
          k = KIND_FILTER;
          case ($urandom_range(0, 9))
            0: smp = SAMPLE_HI[SAMPLE_W-1:0];
            1: smp = SAMPLE_LO[SAMPLE_W-1:0];
            2: smp = smp >>> 12;
            default: ;
          endcase
        end else if (pick < 86) begin
          k   = KIND_COEF;
          sec = 4'($urandom_range(0, MAX_SECTIONS - 1));
          ci  = 3'($urandom_range(COEF_A0, COEF_B2));
          cv  = rand_coef(ci >= COEF_B1 ? 5 : 2);
        end else if (pick < 92) begin
          k = KIND_COEF;
        end else if (pick < 97) begin
          k = KIND_CLEAR;
        end else begin
          k = KIND_UNUSED;
        end
        send_item(k, smp, sec, ci, cv, 1'b0, '0, 1'b0);
      end
      steady = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (pending_outputs.size() != 0)
      $display("%0d results never arrived", pending_outputs.size());
    if (mismatches == 0 && pending_outputs.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> cascaded_biquad_filter.f
hdl/cbq_pkg.sv
hdl/cbq_ram.sv
hdl/cascaded_biquad_filter.sv
verif/cascaded_biquad_filter_test.sv
